// File: src/cau_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_pkg
// Shared operation codes and control types of the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

    localparam int FUNC_W = 2;

    localparam logic [FUNC_W-1:0] FUNC_ADD = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_SUB = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_MUL = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_DIV = 2'd3;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              dz;
        logic              neg_re;
        logic              neg_im;
    } cau_ctrl_t;

    localparam int CTRL_W = $bits(cau_ctrl_t);

endpackage

// File: src/cau_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_front
// Accepts requests, forms the products and sums, and classifies each request
// into sign, magnitude and divisor for the back end.
// ----------------------------------------------------------------------------
module cau_front #(
    parameter int FRAC_BITS = 8,
    parameter int WORD_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [cau_pkg::FUNC_W-1:0]    func,
    input  logic signed [WORD_BITS-1:0]   a_re,
    input  logic signed [WORD_BITS-1:0]   a_im,
    input  logic signed [WORD_BITS-1:0]   b_re,
    input  logic signed [WORD_BITS-1:0]   b_im,
    output logic                          f_valid,
    input  logic                          f_ready,
    output cau_pkg::cau_ctrl_t            f_ctrl,
    output logic [2*WORD_BITS-1:0]        f_mag_re,
    output logic [2*WORD_BITS-1:0]        f_mag_im,
    output logic [2*WORD_BITS-1:0]        f_den
);

    localparam int W  = WORD_BITS;
    localparam int PW = 2 * WORD_BITS;

    logic                      v_reg;
    logic [cau_pkg::FUNC_W-1:0] func_reg;
    logic                      dz_reg;
    logic signed [PW-1:0]      ac_reg, bd_reg, ad_reg, bc_reg, cc_reg, dd_reg;
    logic signed [W:0]         sr_reg, si_reg;

    logic signed [PW:0]        s_re, s_im;
    logic [PW:0]               m_re, m_im;

    assign in_ready = !v_reg || f_ready;
    assign f_valid  = v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            func_reg <= func;
            dz_reg   <= (func == cau_pkg::FUNC_DIV) && (b_re == '0) && (b_im == '0);
            ac_reg   <= a_re * b_re;
            bd_reg   <= a_im * b_im;
            ad_reg   <= a_re * b_im;
            bc_reg   <= a_im * b_re;
            cc_reg   <= b_re * b_re;
            dd_reg   <= b_im * b_im;
            if (func == cau_pkg::FUNC_SUB)
            begin
                sr_reg <= {a_re[W-1], a_re} - {b_re[W-1], b_re};
                si_reg <= {a_im[W-1], a_im} - {b_im[W-1], b_im};
            end
            else
            begin
                sr_reg <= {a_re[W-1], a_re} + {b_re[W-1], b_re};
                si_reg <= {a_im[W-1], a_im} + {b_im[W-1], b_im};
            end
        end
    end

    always_comb
    begin
        unique case (func_reg)
            cau_pkg::FUNC_MUL:
            begin
                s_re = {ac_reg[PW-1], ac_reg} - {bd_reg[PW-1], bd_reg};
                s_im = {ad_reg[PW-1], ad_reg} + {bc_reg[PW-1], bc_reg};
            end
            cau_pkg::FUNC_DIV:
            begin
                s_re = {ac_reg[PW-1], ac_reg} + {bd_reg[PW-1], bd_reg};
                s_im = {bc_reg[PW-1], bc_reg} - {ad_reg[PW-1], ad_reg};
            end
            default:
            begin
                s_re = {{(PW-W){sr_reg[W]}}, sr_reg};
                s_im = {{(PW-W){si_reg[W]}}, si_reg};
            end
        endcase
        m_re = s_re[PW] ? (PW+1)'(-s_re) : s_re;
        m_im = s_im[PW] ? (PW+1)'(-s_im) : s_im;
        if (func_reg == cau_pkg::FUNC_MUL)
        begin
            m_re = m_re >> FRAC_BITS;
            m_im = m_im >> FRAC_BITS;
        end
    end

    assign f_ctrl.func   = func_reg;
    assign f_ctrl.dz     = dz_reg;
    assign f_ctrl.neg_re = s_re[PW];
    assign f_ctrl.neg_im = s_im[PW];
    assign f_mag_re      = m_re[PW-1:0];
    assign f_mag_im      = m_im[PW-1:0];
    assign f_den         = PW'(cc_reg) + PW'(dd_reg);

endmodule

// File: src/cau_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_queue
// Two-entry queue between front and back end.
// ----------------------------------------------------------------------------
module cau_queue #(
    parameter int DATA_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  logic [DATA_W-1:0] push_data,
    output logic              pop_valid,
    input  logic              pop_ready,
    output logic [DATA_W-1:0] pop_data
);

    logic [DATA_W-1:0] mem_reg [2];
    logic              wp_reg, rp_reg;
    logic [1:0]        cnt_reg;
    logic              push, pop;

    assign push_ready = (cnt_reg != 2'd2);
    assign pop_valid  = (cnt_reg != 2'd0);
    assign pop_data   = mem_reg[rp_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= !wp_reg;
            end
            if (pop)
            begin
                rp_reg <= !rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= push_data;
        end
    end

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_reg != 2'd3)
        else $error("queue count out of range");
    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd0 || cnt_reg == 2'd2) |-> wp_reg == rp_reg)
        else $error("queue pointers disagree with count");
    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> cnt_reg == $past(cnt_reg) + 2'd1)
        else $error("queue count did not advance on push");

endmodule

// File: src/cau_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_back
// Pipelined restoring divider, one quotient bit per stage for both parts,
// followed by saturation into the output register.
// ----------------------------------------------------------------------------
module cau_back #(
    parameter int FRAC_BITS = 8,
    parameter int WORD_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          b_valid,
    output logic                          b_ready,
    input  cau_pkg::cau_ctrl_t            b_ctrl,
    input  logic [2*WORD_BITS-1:0]        b_mag_re,
    input  logic [2*WORD_BITS-1:0]        b_mag_im,
    input  logic [2*WORD_BITS-1:0]        b_den,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [WORD_BITS-1:0]   res_re,
    output logic signed [WORD_BITS-1:0]   res_im,
    output logic                          overflow,
    output logic                          div_zero
);

    localparam int W  = WORD_BITS;
    localparam int PW = 2 * WORD_BITS;
    localparam int RW = PW + FRAC_BITS;
    localparam int QW = WORD_BITS + 1;
    localparam int NS = WORD_BITS + 2;

    logic                 en;
    logic [NS-1:0]        v_reg;
    cau_pkg::cau_ctrl_t   ctl_reg [NS];
    logic [RW-1:0]        rr_reg  [NS];
    logic [RW-1:0]        ri_reg  [NS];
    logic [QW-1:0]        qr_reg  [NS];
    logic [QW-1:0]        qi_reg  [NS];
    logic [NS-1:0]        bigr_reg, bigi_reg;
    logic [PW-1:0]        den_reg [NS];

    logic                 ov_reg;
    logic signed [W-1:0]  re_reg, im_reg;
    logic                 dz_reg;

    logic                 is_div0;
    logic [RW-1:0]        n_re, n_im;
    logic [RW-1:0]        fin_re, fin_im;
    logic [W-1:0]         fold_re, fold_im;
    logic                 ov_re, ov_im;

    function automatic logic [W:0] fold(input logic neg, input logic big,
                                        input logic [RW-1:0] mag);
        logic [RW-1:0] lim;
        logic [RW-1:0] negm;
        logic [W:0]    r;
        lim  = RW'(1) << (W - 1);
        negm = RW'(-mag);
        if (neg)
        begin
            if (big || mag > lim)
            begin
                r = {1'b1, 1'b1, {(W-1){1'b0}}};
            end
            else
            begin
                r = {1'b0, negm[W-1:0]};
            end
        end
        else
        begin
            if (big || mag > lim - RW'(1))
            begin
                r = {1'b1, 1'b0, {(W-1){1'b1}}};
            end
            else
            begin
                r = {1'b0, mag[W-1:0]};
            end
        end
        return r;
    endfunction

    assign en      = !out_valid || out_ready;
    assign b_ready = en;

    assign is_div0 = (b_ctrl.func == cau_pkg::FUNC_DIV);
    assign n_re    = is_div0 ? (RW'(b_mag_re) << FRAC_BITS) : RW'(b_mag_re);
    assign n_im    = is_div0 ? (RW'(b_mag_im) << FRAC_BITS) : RW'(b_mag_im);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg     <= '0;
            out_valid <= 1'b0;
        end
        else if (en)
        begin
            v_reg     <= {v_reg[NS-2:0], b_valid};
            out_valid <= v_reg[NS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctl_reg[0]  <= b_ctrl;
            rr_reg[0]   <= n_re;
            ri_reg[0]   <= n_im;
            qr_reg[0]   <= '0;
            qi_reg[0]   <= '0;
            den_reg[0]  <= b_den;
            bigr_reg[0] <= is_div0 && ((n_re >> (W + 1)) >= RW'(b_den));
            bigi_reg[0] <= is_div0 && ((n_im >> (W + 1)) >= RW'(b_den));
        end
    end

    for (genvar i = 1; i < NS; i++)
    begin : g_stage
        localparam int K = W + 1 - i;
        logic          div_on;
        logic          ge_r, ge_i;
        logic [RW-1:0] dsh;

        assign div_on = (ctl_reg[i-1].func == cau_pkg::FUNC_DIV);
        assign dsh    = RW'(den_reg[i-1]) << K;
        assign ge_r   = div_on && ((rr_reg[i-1] >> K) >= RW'(den_reg[i-1]));
        assign ge_i   = div_on && ((ri_reg[i-1] >> K) >= RW'(den_reg[i-1]));

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ctl_reg[i]  <= ctl_reg[i-1];
                den_reg[i]  <= den_reg[i-1];
                bigr_reg[i] <= bigr_reg[i-1];
                bigi_reg[i] <= bigi_reg[i-1];
                rr_reg[i]   <= ge_r ? rr_reg[i-1] - dsh : rr_reg[i-1];
                ri_reg[i]   <= ge_i ? ri_reg[i-1] - dsh : ri_reg[i-1];
                qr_reg[i]   <= {qr_reg[i-1][QW-2:0], ge_r};
                qi_reg[i]   <= {qi_reg[i-1][QW-2:0], ge_i};
            end
        end
    end

    always_comb
    begin
        if (ctl_reg[NS-1].func == cau_pkg::FUNC_DIV)
        begin
            fin_re = RW'(qr_reg[NS-1]);
            fin_im = RW'(qi_reg[NS-1]);
        end
        else
        begin
            fin_re = rr_reg[NS-1];
            fin_im = ri_reg[NS-1];
        end
        {ov_re, fold_re} = fold(ctl_reg[NS-1].neg_re, bigr_reg[NS-1], fin_re);
        {ov_im, fold_im} = fold(ctl_reg[NS-1].neg_im, bigi_reg[NS-1], fin_im);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (ctl_reg[NS-1].dz)
            begin
                re_reg <= '0;
                im_reg <= '0;
                ov_reg <= 1'b0;
                dz_reg <= 1'b1;
            end
            else
            begin
                re_reg <= fold_re;
                im_reg <= fold_im;
                ov_reg <= ov_re || ov_im;
                dz_reg <= 1'b0;
            end
        end
    end

    assign res_re   = re_reg;
    assign res_im   = im_reg;
    assign overflow = ov_reg;
    assign div_zero = dz_reg;

    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && div_zero |-> res_re == '0 && res_im == '0 && !overflow)
        else $error("divide by zero result not cleared");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(v_reg))
        else $error("pipeline moved while output stalled");
    a_big_div: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[0] && ctl_reg[0].func != cau_pkg::FUNC_DIV |-> !bigr_reg[0] && !bigi_reg[0])
        else $error("quotient overflow flagged outside divide");

endmodule

// File: src/complex_arithmetic_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// Complex add, subtract, multiply and divide on signed fixed point operands.
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid / in_ready with func, a_re, a_im, b_re, b_im
//   output channel: out_valid / out_ready with res_re, res_im, overflow,
//   div_zero; one result per request, in request order
//   throughput: one request per cycle, for every operation, while out_ready stays high
//   path: from acceptance to out_valid a request passes one front stage, one
//   queue slot, WORD_BITS + 2 divider stages and one output register; add,
//   subtract and multiply take the same path
//   the divider stages produce one quotient bit of each part per stage
//   results saturate to the word range and raise overflow
//   a divide by zero returns zero with div_zero set
//   reset empties the front stage, queue and divider pipeline
//   when out_valid is high and out_ready low the back end holds; the two-entry queue lets the
//   front keep taking requests until it fills, then in_ready drops
// ----------------------------------------------------------------------------
module complex_arithmetic_unit #(
    parameter int FRAC_BITS = 8,
    parameter int WORD_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [cau_pkg::FUNC_W-1:0]    func,
    input  logic signed [WORD_BITS-1:0]   a_re,
    input  logic signed [WORD_BITS-1:0]   a_im,
    input  logic signed [WORD_BITS-1:0]   b_re,
    input  logic signed [WORD_BITS-1:0]   b_im,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [WORD_BITS-1:0]   res_re,
    output logic signed [WORD_BITS-1:0]   res_im,
    output logic                          overflow,
    output logic                          div_zero
);

    localparam int PW = 2 * WORD_BITS;
    localparam int DW = cau_pkg::CTRL_W + 3 * PW;

    logic                 f_valid, f_ready;
    cau_pkg::cau_ctrl_t   f_ctrl;
    logic [PW-1:0]        f_mag_re, f_mag_im, f_den;
    logic                 q_valid, q_ready;
    logic [DW-1:0]        q_data;
    cau_pkg::cau_ctrl_t   q_ctrl;
    logic [PW-1:0]        q_mag_re, q_mag_im, q_den;

    cau_front #(
        .FRAC_BITS (FRAC_BITS),
        .WORD_BITS (WORD_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .func     (func),
        .a_re     (a_re),
        .a_im     (a_im),
        .b_re     (b_re),
        .b_im     (b_im),
        .f_valid  (f_valid),
        .f_ready  (f_ready),
        .f_ctrl   (f_ctrl),
        .f_mag_re (f_mag_re),
        .f_mag_im (f_mag_im),
        .f_den    (f_den)
    );

    cau_queue #(
        .DATA_W (DW)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  ({f_ctrl, f_mag_re, f_mag_im, f_den}),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_data)
    );

    assign {q_ctrl, q_mag_re, q_mag_im, q_den} = q_data;

    cau_back #(
        .FRAC_BITS (FRAC_BITS),
        .WORD_BITS (WORD_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .b_valid   (q_valid),
        .b_ready   (q_ready),
        .b_ctrl    (q_ctrl),
        .b_mag_re  (q_mag_re),
        .b_mag_im  (q_mag_im),
        .b_den     (q_den),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .res_re    (res_re),
        .res_im    (res_im),
        .overflow  (overflow),
        .div_zero  (div_zero)
    );

    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(overflow && div_zero))
        else $error("overflow and divide by zero both set");
    a_ovf_rail: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && overflow |-> (res_re[WORD_BITS-2:0] == '1 || res_re[WORD_BITS-2:0] == '0
                                   || res_im[WORD_BITS-2:0] == '1
                                   || res_im[WORD_BITS-2:0] == '0))
        else $error("overflow without a saturated part");
    a_queue_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        f_valid && !f_ready |-> q_valid)
        else $error("queue full but reports empty");

endmodule
